### hw/rtl/frd_pkg.sv
// Shared types and constants for the dielectric Fresnel reflectance block.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
`default_nettype none

package frd_pkg;

    // Port and field widths
    localparam int COS_W    = 16;   // cosine, signed Q2.14
    localparam int IDX_W    = 16;   // refractive index, unsigned Q4.12
    localparam int REFL_W   = 17;   // reflectance, unsigned Q1.16
    localparam int CFG_IDX_W = 8;   // config register index

    // Internal arithmetic widths
    localparam int FRAC_W   = 14;   // fraction bits of Q.14 values
    localparam int C_W      = 15;   // clamped cosine magnitude, up to 1.0
    localparam int X_W      = 29;   // square root radicand, up to 2^28
    localparam int ROOT_W   = 15;   // square root result, up to 2^14
    localparam int TRIAL_W  = X_W + 2;
    localparam int P_W      = 31;   // 16 x 15 products
    localparam int SO_W     = 28;   // transmitted sine, Q.28
    localparam int SQ_W     = 2 * SO_W;
    localparam int DREM1_W  = 17;   // remainder of the sine divider
    localparam int RAT_W    = 31;   // reflection ratio, Q.30, up to 1.0
    localparam int DEN_W    = 32;   // ratio denominator
    localparam int RSQ_W    = 2 * RAT_W;
    localparam int SUM_W    = RSQ_W + 1;
    localparam int OUT_SHIFT = 45;  // Q.60 sum of squares to mean in Q.16

    // Constants
    localparam logic signed [COS_W-1:0] COS_ONE     = 16'sd16384;
    localparam logic signed [COS_W-1:0] COS_NEG_ONE = -16'sd16384;
    localparam logic [IDX_W-1:0]  INCIDENT_RESET    = 16'd4096;
    localparam logic [IDX_W-1:0]  TRANSMITTED_RESET = 16'd6144;
    localparam logic [REFL_W-1:0] REFL_ONE          = 17'd65536;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_INCIDENT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_TRANSMITTED = 8'd1;

    // Input queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Classified item held in the queue: index swap and cosine magnitude
    typedef struct packed {
        logic           neg;
        logic [C_W-1:0] mag;
    } frd_item_t;

    // Sideband that travels with an item through the back pipeline
    typedef struct packed {
        logic           neg;
        logic [C_W-1:0] mag;
        logic           tir;
    } frd_side_t;

endpackage

`default_nettype wire

### hw/rtl/frd_front.sv
// Front end: input handshake, cosine clamp and index-swap classification.
// Depends on frd_pkg.
`default_nettype none

module frd_front (
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [frd_pkg::COS_W-1:0]   cos_incidence,
    input  logic                               fifo_full,
    output logic                               push,
    output frd_pkg::frd_item_t                 push_item
);

    logic signed [frd_pkg::COS_W-1:0] cos_clamped;

    // Take a transfer whenever the queue has room
    assign in_ready = !fifo_full;
    assign push     = in_valid && !fifo_full;

    // Clamp to [-1, 1] in Q2.14
    always_comb
    begin
        if (cos_incidence > frd_pkg::COS_ONE)
        begin
            cos_clamped = frd_pkg::COS_ONE;
        end
        else if (cos_incidence < frd_pkg::COS_NEG_ONE)
        begin
            cos_clamped = frd_pkg::COS_NEG_ONE;
        end
        else
        begin
            cos_clamped = cos_incidence;
        end
    end

    // Negative cosine: swap the media and use the magnitude
    always_comb
    begin
        push_item.neg = cos_clamped[frd_pkg::COS_W-1];
        if (cos_clamped[frd_pkg::COS_W-1])
        begin
            push_item.mag = frd_pkg::C_W'(-cos_clamped);
        end
        else
        begin
            push_item.mag = frd_pkg::C_W'(cos_clamped);
        end
    end

endmodule

`default_nettype wire

### hw/rtl/frd_fifo.sv
// Short queue between the front end and the arithmetic pipeline.
// Depends on frd_pkg.
`default_nettype none

module frd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  frd_pkg::frd_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output frd_pkg::frd_item_t pop_item
);

    frd_pkg::frd_item_t                 entry_reg [frd_pkg::FIFO_DEPTH];
    logic [frd_pkg::FIFO_PTR_W-1:0]     wr_ptr_reg;
    logic [frd_pkg::FIFO_PTR_W-1:0]     rd_ptr_reg;
    logic [frd_pkg::FIFO_CNT_W-1:0]     count_reg;
    logic [frd_pkg::FIFO_CNT_W-1:0]     count_next;

    assign full      = (count_reg == frd_pkg::FIFO_CNT_W'(frd_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/frd_sqrt.sv
// Pipelined floor square root, one result bit per stage, with an item sideband.
// Depends on frd_pkg.
`default_nettype none

module frd_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [frd_pkg::X_W-1:0]         in_radicand,
    input  frd_pkg::frd_side_t              in_side,
    output logic                            out_valid,
    output logic [frd_pkg::ROOT_W-1:0]      out_root,
    output frd_pkg::frd_side_t              out_side
);

    localparam int N = frd_pkg::ROOT_W;

    logic                        vld_reg  [N];
    logic [frd_pkg::X_W-1:0]     rem_reg  [N];
    logic [N-1:0]                root_reg [N];
    frd_pkg::frd_side_t          side_reg [N];

    generate
        for (genvar k = 0; k < N; k++)
        begin : g_step
            localparam int B = N - 1 - k;

            logic                           v_in;
            logic [frd_pkg::X_W-1:0]        r_in;
            logic [N-1:0]                   q_in;
            frd_pkg::frd_side_t             s_in;
            logic [frd_pkg::TRIAL_W-1:0]    trial;
            logic                           take;

            if (k == 0)
            begin : g_first
                assign v_in = in_valid;
                assign r_in = in_radicand;
                assign q_in = '0;
                assign s_in = in_side;
            end
            else
            begin : g_rest
                assign v_in = vld_reg[k-1];
                assign r_in = rem_reg[k-1];
                assign q_in = root_reg[k-1];
                assign s_in = side_reg[k-1];
            end

            // (q + 2^B)^2 - q^2 = q * 2^(B+1) + 2^(2B)
            assign trial = (frd_pkg::TRIAL_W'(q_in) << (B + 1))
                         | (frd_pkg::TRIAL_W'(1) << (2 * B));
            assign take  = (frd_pkg::TRIAL_W'(r_in) >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= take ? (r_in - trial[frd_pkg::X_W-1:0]) : r_in;
                    root_reg[k] <= take ? (q_in | (N'(1) << B)) : q_in;
                    side_reg[k] <= s_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

`default_nettype wire

### hw/rtl/frd_back.sv
// Back end: stalling arithmetic pipeline from queue head to the output register.
// Depends on frd_pkg and frd_sqrt.
`default_nettype none

module frd_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [frd_pkg::IDX_W-1:0]       index_incident,
    input  logic [frd_pkg::IDX_W-1:0]       index_transmitted,
    input  logic                            fifo_valid,
    input  frd_pkg::frd_item_t              fifo_item,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [frd_pkg::REFL_W-1:0]      reflectance,
    output logic                            total_internal
);

    localparam int D1 = frd_pkg::SO_W;
    localparam int D2 = frd_pkg::RAT_W;
    localparam logic [frd_pkg::X_W-1:0]  ONE_SQ_Q28 = frd_pkg::X_W'(1) << 28;
    localparam logic [frd_pkg::SQ_W:0]   ONE_SQ_Q56 = (frd_pkg::SQ_W + 1)'(1) << 56;
    localparam logic [frd_pkg::RAT_W-1:0] RAT_ONE   = frd_pkg::RAT_W'(1) << 30;
    localparam logic [frd_pkg::SUM_W-1:0] ROUND_HALF = frd_pkg::SUM_W'(1) << 44;

    // Media after the swap for a negative cosine
    function automatic logic [frd_pkg::IDX_W-1:0] pick_n1(
        input logic neg, input logic [frd_pkg::IDX_W-1:0] ni,
        input logic [frd_pkg::IDX_W-1:0] nt);
        pick_n1 = neg ? nt : ni;
    endfunction

    function automatic logic [frd_pkg::IDX_W-1:0] pick_n2(
        input logic neg, input logic [frd_pkg::IDX_W-1:0] ni,
        input logic [frd_pkg::IDX_W-1:0] nt);
        pick_n2 = neg ? ni : nt;
    endfunction

    logic en;
    logic out_valid_reg;
    logic [frd_pkg::REFL_W-1:0] refl_reg;
    logic tir_reg;

    // Whole pipeline advances when the output register is free or drained
    assign en  = !out_valid_reg || out_ready;
    assign pop = en && fifo_valid;

    // Entry stage: radicand 1 - c^2
    logic                       e_vld_reg;
    logic [frd_pkg::X_W-1:0]    e_x_reg;
    frd_pkg::frd_side_t         e_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e_vld_reg <= fifo_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_x_reg <= ONE_SQ_Q28
                     - frd_pkg::X_W'(fifo_item.mag) * frd_pkg::X_W'(fifo_item.mag);
            e_side_reg.neg <= fifo_item.neg;
            e_side_reg.mag <= fifo_item.mag;
            e_side_reg.tir <= 1'b0;
        end
    end

    // Incident sine
    logic                           s1_vld;
    logic [frd_pkg::ROOT_W-1:0]     s1_root;
    frd_pkg::frd_side_t             s1_side;

    frd_sqrt u_sqrt_incident (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (e_vld_reg),
        .in_radicand (e_x_reg),
        .in_side     (e_side_reg),
        .out_valid   (s1_vld),
        .out_root    (s1_root),
        .out_side    (s1_side)
    );

    // Snell product si*n1 and the total internal reflection test
    logic [frd_pkg::IDX_W-1:0]  m_n1;
    logic [frd_pkg::IDX_W-1:0]  m_n2;
    logic [frd_pkg::P_W-1:0]    m_prod;
    logic                       m_vld_reg;
    logic [frd_pkg::P_W-1:0]    m_p_reg;
    frd_pkg::frd_side_t         m_side_reg;

    assign m_n1   = pick_n1(s1_side.neg, index_incident, index_transmitted);
    assign m_n2   = pick_n2(s1_side.neg, index_incident, index_transmitted);
    assign m_prod = frd_pkg::P_W'(s1_root) * frd_pkg::P_W'(m_n1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m_vld_reg <= s1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_p_reg        <= m_prod;
            m_side_reg.neg <= s1_side.neg;
            m_side_reg.mag <= s1_side.mag;
            m_side_reg.tir <= (m_prod >= {1'b0, m_n2, frd_pkg::FRAC_W'(0)});
        end
    end

    // Transmitted sine: (si*n1 << 14) / n2, one quotient bit per stage
    logic                           d1_vld_reg  [D1];
    logic [frd_pkg::DREM1_W-1:0]    d1_rem_reg  [D1];
    logic [D1-1:0]                  d1_q_reg    [D1];
    logic [frd_pkg::P_W-1:0]        d1_p_reg    [D1];
    frd_pkg::frd_side_t             d1_side_reg [D1];

    generate
        for (genvar k = 0; k < D1; k++)
        begin : g_div_sine
            localparam int B = D1 - 1 - k;

            logic                           v_in;
            logic [frd_pkg::DREM1_W-1:0]    r_in;
            logic [D1-1:0]                  q_in;
            logic [frd_pkg::P_W-1:0]        p_in;
            frd_pkg::frd_side_t             s_in;
            logic                           bit_in;
            logic [frd_pkg::DREM1_W:0]      t;
            logic [frd_pkg::IDX_W-1:0]      n2;
            logic                           take;

            if (k == 0)
            begin : g_first
                assign v_in = m_vld_reg;
                assign r_in = m_p_reg[frd_pkg::P_W-1:frd_pkg::FRAC_W];
                assign q_in = '0;
                assign p_in = m_p_reg;
                assign s_in = m_side_reg;
            end
            else
            begin : g_rest
                assign v_in = d1_vld_reg[k-1];
                assign r_in = d1_rem_reg[k-1];
                assign q_in = d1_q_reg[k-1];
                assign p_in = d1_p_reg[k-1];
                assign s_in = d1_side_reg[k-1];
            end

            // Low dividend bits past the product are the zeros of the shift
            if (B >= frd_pkg::FRAC_W)
            begin : g_bit
                assign bit_in = p_in[B - frd_pkg::FRAC_W];
            end
            else
            begin : g_zero
                assign bit_in = 1'b0;
            end

            assign n2   = pick_n2(s_in.neg, index_incident, index_transmitted);
            assign t    = {r_in, bit_in};
            assign take = (t >= (frd_pkg::DREM1_W + 1)'(n2));

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    d1_vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    d1_vld_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d1_rem_reg[k]  <= take
                        ? frd_pkg::DREM1_W'(t - (frd_pkg::DREM1_W + 1)'(n2))
                        : frd_pkg::DREM1_W'(t);
                    d1_q_reg[k]    <= take ? (q_in | (D1'(1) << B)) : q_in;
                    d1_p_reg[k]    <= p_in;
                    d1_side_reg[k] <= s_in;
                end
            end
        end
    endgenerate

    // Square of the transmitted sine
    logic                       q_vld_reg;
    logic [frd_pkg::SQ_W-1:0]   q_sq_reg;
    frd_pkg::frd_side_t         q_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            q_vld_reg <= d1_vld_reg[D1-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_sq_reg   <= frd_pkg::SQ_W'(d1_q_reg[D1-1]) * frd_pkg::SQ_W'(d1_q_reg[D1-1]);
            q_side_reg <= d1_side_reg[D1-1];
        end
    end

    // Transmitted cosine: isqrt(2^56 - so^2) >> 14 equals isqrt of the top bits
    logic [frd_pkg::SQ_W:0]         q_diff;
    logic                           s2_vld;
    logic [frd_pkg::ROOT_W-1:0]     s2_root;
    frd_pkg::frd_side_t             s2_side;

    assign q_diff = ONE_SQ_Q56 - {1'b0, q_sq_reg};

    frd_sqrt u_sqrt_transmitted (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (q_vld_reg),
        .in_radicand (q_diff[frd_pkg::SQ_W:28]),
        .in_side     (q_side_reg),
        .out_valid   (s2_vld),
        .out_root    (s2_root),
        .out_side    (s2_side)
    );

    // Four index products for the s and p ratios
    logic [frd_pkg::IDX_W-1:0]  r_n1;
    logic [frd_pkg::IDX_W-1:0]  r_n2;
    logic                       r_vld_reg;
    logic [frd_pkg::P_W-1:0]    r_as_reg;
    logic [frd_pkg::P_W-1:0]    r_bs_reg;
    logic [frd_pkg::P_W-1:0]    r_ap_reg;
    logic [frd_pkg::P_W-1:0]    r_bp_reg;
    frd_pkg::frd_side_t         r_side_reg;

    assign r_n1 = pick_n1(s2_side.neg, index_incident, index_transmitted);
    assign r_n2 = pick_n2(s2_side.neg, index_incident, index_transmitted);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            r_vld_reg <= s2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_as_reg   <= frd_pkg::P_W'(r_n2) * frd_pkg::P_W'(s2_side.mag);
            r_bs_reg   <= frd_pkg::P_W'(r_n1) * frd_pkg::P_W'(s2_root);
            r_ap_reg   <= frd_pkg::P_W'(r_n1) * frd_pkg::P_W'(s2_side.mag);
            r_bp_reg   <= frd_pkg::P_W'(r_n2) * frd_pkg::P_W'(s2_root);
            r_side_reg <= s2_side;
        end
    end

    // Ratio numerators and denominators
    logic                           n_vld_reg;
    logic [frd_pkg::P_W-1:0]        n_num_s_reg;
    logic [frd_pkg::P_W-1:0]        n_num_p_reg;
    logic [frd_pkg::DEN_W-1:0]      n_den_s_reg;
    logic [frd_pkg::DEN_W-1:0]      n_den_p_reg;
    frd_pkg::frd_side_t             n_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            n_vld_reg <= r_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_num_s_reg <= (r_as_reg >= r_bs_reg) ? (r_as_reg - r_bs_reg)
                                                  : (r_bs_reg - r_as_reg);
            n_num_p_reg <= (r_ap_reg >= r_bp_reg) ? (r_ap_reg - r_bp_reg)
                                                  : (r_bp_reg - r_ap_reg);
            n_den_s_reg <= frd_pkg::DEN_W'(r_as_reg) + frd_pkg::DEN_W'(r_bs_reg);
            n_den_p_reg <= frd_pkg::DEN_W'(r_ap_reg) + frd_pkg::DEN_W'(r_bp_reg);
            n_side_reg  <= r_side_reg;
        end
    end

    // Ratio dividers: (num << 30) / den for s and p side by side
    logic                           d2_vld_reg   [D2];
    logic [frd_pkg::DEN_W-1:0]      d2_rem_s_reg [D2];
    logic [frd_pkg::DEN_W-1:0]      d2_rem_p_reg [D2];
    logic [D2-1:0]                  d2_q_s_reg   [D2];
    logic [D2-1:0]                  d2_q_p_reg   [D2];
    logic [frd_pkg::DEN_W-1:0]      d2_den_s_reg [D2];
    logic [frd_pkg::DEN_W-1:0]      d2_den_p_reg [D2];
    frd_pkg::frd_side_t             d2_side_reg  [D2];

    generate
        for (genvar k = 0; k < D2; k++)
        begin : g_div_ratio
            localparam int B = D2 - 1 - k;

            logic                           v_in;
            logic [frd_pkg::DEN_W-1:0]      rs_in;
            logic [frd_pkg::DEN_W-1:0]      rp_in;
            logic [D2-1:0]                  qs_in;
            logic [D2-1:0]                  qp_in;
            logic [frd_pkg::DEN_W-1:0]      ds_in;
            logic [frd_pkg::DEN_W-1:0]      dp_in;
            frd_pkg::frd_side_t             s_in;
            logic                           bs_in;
            logic                           bp_in;
            logic [frd_pkg::DEN_W:0]        ts;
            logic [frd_pkg::DEN_W:0]        tp;
            logic                           take_s;
            logic                           take_p;

            if (k == 0)
            begin : g_first
                assign v_in  = n_vld_reg;
                assign rs_in = frd_pkg::DEN_W'(n_num_s_reg[frd_pkg::P_W-1:1]);
                assign rp_in = frd_pkg::DEN_W'(n_num_p_reg[frd_pkg::P_W-1:1]);
                assign qs_in = '0;
                assign qp_in = '0;
                assign ds_in = n_den_s_reg;
                assign dp_in = n_den_p_reg;
                assign s_in  = n_side_reg;
                assign bs_in = n_num_s_reg[0];
                assign bp_in = n_num_p_reg[0];
            end
            else
            begin : g_rest
                assign v_in  = d2_vld_reg[k-1];
                assign rs_in = d2_rem_s_reg[k-1];
                assign rp_in = d2_rem_p_reg[k-1];
                assign qs_in = d2_q_s_reg[k-1];
                assign qp_in = d2_q_p_reg[k-1];
                assign ds_in = d2_den_s_reg[k-1];
                assign dp_in = d2_den_p_reg[k-1];
                assign s_in  = d2_side_reg[k-1];
                assign bs_in = 1'b0;
                assign bp_in = 1'b0;
            end

            assign ts     = {rs_in, bs_in};
            assign tp     = {rp_in, bp_in};
            assign take_s = (ts >= {1'b0, ds_in});
            assign take_p = (tp >= {1'b0, dp_in});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    d2_vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    d2_vld_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d2_rem_s_reg[k] <= take_s ? frd_pkg::DEN_W'(ts - {1'b0, ds_in})
                                              : frd_pkg::DEN_W'(ts);
                    d2_rem_p_reg[k] <= take_p ? frd_pkg::DEN_W'(tp - {1'b0, dp_in})
                                              : frd_pkg::DEN_W'(tp);
                    d2_q_s_reg[k]   <= take_s ? (qs_in | (D2'(1) << B)) : qs_in;
                    d2_q_p_reg[k]   <= take_p ? (qp_in | (D2'(1) << B)) : qp_in;
                    d2_den_s_reg[k] <= ds_in;
                    d2_den_p_reg[k] <= dp_in;
                    d2_side_reg[k]  <= s_in;
                end
            end
        end
    endgenerate

    // Squares of the ratios; a zero denominator counts as a ratio of one
    logic [frd_pkg::RAT_W-1:0]  w_rs;
    logic [frd_pkg::RAT_W-1:0]  w_rp;
    logic                       w_vld_reg;
    logic [frd_pkg::RSQ_W-1:0]  w_sq_s_reg;
    logic [frd_pkg::RSQ_W-1:0]  w_sq_p_reg;
    logic                       w_tir_reg;

    assign w_rs = (d2_den_s_reg[D2-1] == '0) ? RAT_ONE : d2_q_s_reg[D2-1];
    assign w_rp = (d2_den_p_reg[D2-1] == '0) ? RAT_ONE : d2_q_p_reg[D2-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            w_vld_reg <= d2_vld_reg[D2-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_sq_s_reg <= frd_pkg::RSQ_W'(w_rs) * frd_pkg::RSQ_W'(w_rs);
            w_sq_p_reg <= frd_pkg::RSQ_W'(w_rp) * frd_pkg::RSQ_W'(w_rp);
            w_tir_reg  <= d2_side_reg[D2-1].tir;
        end
    end

    // Mean, rounded half up to Q1.16 and saturated at one; total internal reflection gives one
    localparam int OUT_SHIFT_W = frd_pkg::OUT_SHIFT;

    logic [frd_pkg::SUM_W-1:0]              f_sum;
    logic [frd_pkg::SUM_W-OUT_SHIFT_W-1:0]  f_mean;
    logic [frd_pkg::REFL_W-1:0]             f_refl;

    assign f_sum  = frd_pkg::SUM_W'(w_sq_s_reg) + frd_pkg::SUM_W'(w_sq_p_reg) + ROUND_HALF;
    assign f_mean = f_sum[frd_pkg::SUM_W-1:OUT_SHIFT_W];

    always_comb
    begin
        if (w_tir_reg || (f_mean > (frd_pkg::SUM_W - OUT_SHIFT_W)'(frd_pkg::REFL_ONE)))
        begin
            f_refl = frd_pkg::REFL_ONE;
        end
        else
        begin
            f_refl = frd_pkg::REFL_W'(f_mean);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= w_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            refl_reg <= f_refl;
            tir_reg  <= w_tir_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign reflectance    = refl_reg;
    assign total_internal = tir_reg;

endmodule

`default_nettype wire

### hw/rtl/fresnel_dielectric_reflectance.sv
// Unpolarized Fresnel reflectance between two dielectrics, top level.
// Depends on frd_pkg, frd_front, frd_fifo and frd_back.
//
// Usage: the input channel (in_valid/in_ready) carries cos_incidence in signed
// Q2.14; the output channel (out_valid/out_ready) returns reflectance in
// unsigned Q1.16 (65536 is 1.0) and total_internal. One result per input,
// in order. The configuration channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data) writes index_incident (index 0) and index_transmitted (index 1),
// Q4.12; other indexes are dropped. cfg_ready is always high; write only
// while no item is in flight.
// Throughput: one transfer per cycle in each direction while out_ready is high.
// Path from input transfer to out_valid: a 4-entry queue, two 15-stage square
// roots, a 28-stage and a 31-stage divider (one quotient bit per stage) and
// multiply stages.
// Stall: while out_valid is high and out_ready low the arithmetic pipeline holds;
// the queue absorbs up to four more items, after which in_ready drops.
// Reset: pipeline and queue empty, indices 1.0 and 1.5.
`default_nettype none

module fresnel_dielectric_reflectance (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [frd_pkg::COS_W-1:0]    cos_incidence,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [frd_pkg::REFL_W-1:0]          reflectance,
    output logic                                total_internal,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [frd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [frd_pkg::IDX_W-1:0]           cfg_data
);

    logic [frd_pkg::IDX_W-1:0]  index_incident_reg;
    logic [frd_pkg::IDX_W-1:0]  index_transmitted_reg;
    logic                       push;
    frd_pkg::frd_item_t         push_item;
    logic                       fifo_full;
    logic                       pop;
    logic                       fifo_valid;
    frd_pkg::frd_item_t         fifo_item;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_incident_reg    <= frd_pkg::INCIDENT_RESET;
            index_transmitted_reg <= frd_pkg::TRANSMITTED_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                frd_pkg::CFG_INDEX_INCIDENT:    index_incident_reg    <= cfg_data;
                frd_pkg::CFG_INDEX_TRANSMITTED: index_transmitted_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    frd_front u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cos_incidence (cos_incidence),
        .fifo_full     (fifo_full),
        .push          (push),
        .push_item     (push_item)
    );

    frd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .not_empty (fifo_valid),
        .pop_item  (fifo_item)
    );

    frd_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .index_incident    (index_incident_reg),
        .index_transmitted (index_transmitted_reg),
        .fifo_valid        (fifo_valid),
        .fifo_item         (fifo_item),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .reflectance       (reflectance),
        .total_internal    (total_internal)
    );

endmodule

`default_nettype wire
